// ===== design/euler_to_quaternion_macros.svh =====
// Assertion macros for the euler_to_quaternion block.
// Uses clk and rst_n of the module that includes it.
`ifndef EULER_TO_QUATERNION_MACROS_SVH
`define EULER_TO_QUATERNION_MACROS_SVH

// condition holds at every edge out of reset
`define ETQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ETQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/etq_pkg.sv =====
// Package for euler_to_quaternion: item types, fixed-point constants,
// CORDIC arctangent table and Q14 rounding/saturation. No dependencies.
package etq_pkg;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
  } etq_in_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } etq_out_t;

  localparam int CW     = 34;  // CORDIC datapath width, Q30 plus headroom
  localparam int STEPS  = 30;  // CORDIC iterations
  localparam int SCW    = 22;  // Q20 sine/cosine width
  localparam int PW     = 2 * SCW;  // product of two Q20 terms
  localparam int TW     = 64;  // Q60 triple product / sum

  localparam logic signed [CW-1:0] Q30_HALF_PI = 34'sd1686629713;
  localparam logic signed [CW-1:0] Q30_PI      = 34'sd3373259426;
  localparam logic signed [CW-1:0] Q30_GAIN    = 34'sd652032874;
  localparam logic signed [15:0]   Q14_ONE     = 16'sd16384;

  function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] idx);
    logic signed [CW-1:0] v;
    unique case (idx)
      5'd0:  v = 34'sh3243F6A8;
      5'd1:  v = 34'sh1DAC6705;
      5'd2:  v = 34'sh0FADBAFC;
      5'd3:  v = 34'sh07F56EA6;
      5'd4:  v = 34'sh03FEAB76;
      5'd5:  v = 34'sh01FFD55B;
      5'd6:  v = 34'sh00FFFAAA;
      5'd7:  v = 34'sh007FFF55;
      5'd8:  v = 34'sh003FFFEA;
      5'd9:  v = 34'sh001FFFFD;
      5'd10: v = 34'sh000FFFFF;
      5'd11: v = 34'sh0007FFFF;
      5'd12: v = 34'sh0003FFFF;
      5'd13: v = 34'sh0001FFFF;
      5'd14: v = 34'sh0000FFFF;
      5'd15: v = 34'sh00007FFF;
      5'd16: v = 34'sh00003FFF;
      5'd17: v = 34'sh00001FFF;
      5'd18: v = 34'sh00000FFF;
      5'd19: v = 34'sh000007FF;
      5'd20: v = 34'sh000003FF;
      5'd21: v = 34'sh000001FF;
      5'd22: v = 34'sh000000FF;
      5'd23: v = 34'sh0000007F;
      5'd24: v = 34'sh0000003F;
      5'd25: v = 34'sh0000001F;
      5'd26: v = 34'sh0000000F;
      5'd27: v = 34'sh00000008;
      5'd28: v = 34'sh00000004;
      5'd29: v = 34'sh00000002;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Q60 -> Q14, round half up, clamp to +/-1.0
  function automatic logic signed [15:0] q60_to_q14(input logic signed [TW-1:0] s);
    logic signed [TW-1:0] t;
    logic signed [17:0]   r;
    logic signed [15:0]   q;
    t = s + (64'sd1 <<< 45);
    r = 18'(t >>> 46);
    if (r > 18'sd16384)       q = Q14_ONE;
    else if (r < -18'sd16384) q = -Q14_ONE;
    else                      q = 16'(r);
    return q;
  endfunction

endpackage

// ===== design/euler_to_quaternion.sv =====
// Top level of euler_to_quaternion: ZYX Euler angles to unit quaternion.
// Depends on etq_pkg and euler_to_quaternion_macros.svh.
//
// Fully pipelined: one angle triple (Q2.13) may be started every cycle and
// busy never rises. Each item gives one quaternion (Q1.14, clamped to +/-1)
// on out_data, marked by a one-cycle out_valid strobe. The receiver cannot
// hold results off, so out_data must be captured in the strobe cycle. The
// pipeline holds input, fold, the 30-stage unrolled CORDIC (one iteration
// per stage, three lanes side by side, one per angle), rounding, three
// multiply/add stages (P1 to P3) and the sum and output stage (P4).
`include "euler_to_quaternion_macros.svh"

module euler_to_quaternion (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  etq_pkg::etq_in_t   in_data,
  output logic               out_valid,
  output etq_pkg::etq_out_t  out_data
);
  import etq_pkg::*;

  // never stalls
  assign busy = 1'b0;

  // ---- input register ----
  logic                     in_vld_r;
  logic signed [15:0]       ang_r [0:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    ang_r[0] <= in_data.roll_angle;
    ang_r[1] <= in_data.pitch_angle;
    ang_r[2] <= in_data.yaw_angle;
  end

  // ---- CORDIC lanes: index 0 is the folded angle, index k after k steps ----
  logic                     vld_r [0:STEPS];
  logic signed [CW-1:0]     cx_r  [0:2][0:STEPS];
  logic signed [CW-1:0]     cy_r  [0:2][0:STEPS];
  logic signed [CW-1:0]     cz_r  [0:2][0:STEPS];
  logic                     neg_r [0:2][0:STEPS];

  // Raw Q2.13 read as Q1.14 is the half angle; widen to Q30 and fold
  // into +/- pi/2, remembering to flip the cosine.
  logic signed [CW-1:0]     zin   [0:2];
  logic signed [CW-1:0]     zfold [0:2];
  logic                     nfold [0:2];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      zin[a] = {{(CW-32){ang_r[a][15]}}, ang_r[a], 16'b0};
      if (zin[a] > Q30_HALF_PI) begin
        zfold[a] = Q30_PI - zin[a];
        nfold[a] = 1'b1;
      end else if (zin[a] < -Q30_HALF_PI) begin
        zfold[a] = -Q30_PI - zin[a];
        nfold[a] = 1'b1;
      end else begin
        zfold[a] = zin[a];
        nfold[a] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld_r;
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_lane0
    always_ff @(posedge clk) begin
      cx_r[a][0]  <= Q30_GAIN;
      cy_r[a][0]  <= '0;
      cz_r[a][0]  <= zfold[a];
      neg_r[a][0] <= nfold[a];
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    for (genvar a = 0; a < 3; a++) begin : g_lane
      always_ff @(posedge clk) begin
        neg_r[a][i+1] <= neg_r[a][i];
        if (!cz_r[a][i][CW-1]) begin
          cx_r[a][i+1] <= cx_r[a][i] - (cy_r[a][i] >>> i);
          cy_r[a][i+1] <= cy_r[a][i] + (cx_r[a][i] >>> i);
          cz_r[a][i+1] <= cz_r[a][i] - atan_q30(5'(i));
        end else begin
          cx_r[a][i+1] <= cx_r[a][i] + (cy_r[a][i] >>> i);
          cy_r[a][i+1] <= cy_r[a][i] - (cx_r[a][i] >>> i);
          cz_r[a][i+1] <= cz_r[a][i] + atan_q30(5'(i));
        end
      end
    end
  end

  // ---- round Q30 -> Q20, apply cosine sign ----
  logic                     rnd_vld_r;
  logic signed [SCW-1:0]    s20_r [0:2];
  logic signed [SCW-1:0]    c20_r [0:2];
  logic signed [CW-1:0]     cfin  [0:2];
  logic signed [CW-1:0]     crnd  [0:2];
  logic signed [CW-1:0]     srnd  [0:2];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      cfin[a] = neg_r[a][STEPS] ? -cx_r[a][STEPS] : cx_r[a][STEPS];
      crnd[a] = cfin[a] + 34'sd512;
      srnd[a] = cy_r[a][STEPS] + 34'sd512;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_vld_r <= 1'b0;
    end else begin
      rnd_vld_r <= vld_r[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      s20_r[a] <= SCW'(srnd[a] >>> 10);
      c20_r[a] <= SCW'(crnd[a] >>> 10);
    end
  end

  // ---- P1: roll x pitch pairs, yaw terms carried along ----
  logic                     p1_vld_r;
  logic signed [PW-1:0]     cc_r, ss_r, sc_r, cs_r;
  logic signed [SCW-1:0]    sy1_r, cy1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= rnd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    cc_r  <= c20_r[0] * c20_r[1];
    ss_r  <= s20_r[0] * s20_r[1];
    sc_r  <= s20_r[0] * c20_r[1];
    cs_r  <= c20_r[0] * s20_r[1];
    sy1_r <= s20_r[2];
    cy1_r <= c20_r[2];
  end

  // ---- P2: pair x yaw term, split into high and low partial products ----
  // order: w = t0 + t1, x = t2 - t3, y = t4 + t5, z = t6 - t7
  logic signed [PW-1:0]     tp_pair [0:7];
  logic signed [SCW-1:0]    tp_yaw  [0:7];
  logic signed [SCW-1:0]    tp_hi   [0:7];
  logic signed [SCW:0]      tp_lo   [0:7];

  always_comb begin
    tp_pair[0] = cc_r;  tp_yaw[0] = cy1_r;
    tp_pair[1] = ss_r;  tp_yaw[1] = sy1_r;
    tp_pair[2] = sc_r;  tp_yaw[2] = cy1_r;
    tp_pair[3] = cs_r;  tp_yaw[3] = sy1_r;
    tp_pair[4] = cs_r;  tp_yaw[4] = cy1_r;
    tp_pair[5] = sc_r;  tp_yaw[5] = sy1_r;
    tp_pair[6] = cc_r;  tp_yaw[6] = sy1_r;
    tp_pair[7] = ss_r;  tp_yaw[7] = cy1_r;
    for (int t = 0; t < 8; t++) begin
      tp_hi[t] = tp_pair[t][PW-1:SCW];
      tp_lo[t] = {1'b0, tp_pair[t][SCW-1:0]};
    end
  end

  logic                     p2_vld_r;
  logic signed [PW-1:0]     ph_r [0:7];
  logic signed [PW:0]       pl_r [0:7];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
    end else begin
      p2_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int t = 0; t < 8; t++) begin
      ph_r[t] <= tp_hi[t] * tp_yaw[t];
      pl_r[t] <= tp_lo[t] * tp_yaw[t];
    end
  end

  // ---- P3: recombine partials into Q60 triple products ----
  logic                     p3_vld_r;
  logic signed [TW-1:0]     tri_r [0:7];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_vld_r <= 1'b0;
    end else begin
      p3_vld_r <= p2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int t = 0; t < 8; t++) begin
      tri_r[t] <= (TW'(ph_r[t]) <<< SCW) + TW'(pl_r[t]);
    end
  end

  // ---- P4: sums, round to Q14, clamp, output register ----
  logic                     out_vld_r;
  etq_out_t                 out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= p3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_r.quat_w <= q60_to_q14(tri_r[0] + tri_r[1]);
    out_r.quat_x <= q60_to_q14(tri_r[2] - tri_r[3]);
    out_r.quat_y <= q60_to_q14(tri_r[4] + tri_r[5]);
    out_r.quat_z <= q60_to_q14(tri_r[6] - tri_r[7]);
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // ---- checks ----
  logic out_in_range;

  assign out_in_range =
    (out_data.quat_w <= Q14_ONE) && (out_data.quat_w >= -Q14_ONE) &&
    (out_data.quat_x <= Q14_ONE) && (out_data.quat_x >= -Q14_ONE) &&
    (out_data.quat_y <= Q14_ONE) && (out_data.quat_y >= -Q14_ONE) &&
    (out_data.quat_z <= Q14_ONE) && (out_data.quat_z >= -Q14_ONE);

  `ETQ_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised on a stall-free pipeline")
  `ETQ_ASSERT_NEXT(a_p3_to_out, p3_vld_r, out_valid, "product stage item lost before output")
  `ETQ_ASSERT_ALWAYS(a_out_clamped, !out_valid || out_in_range, "component beyond +/-1")

endmodule
